// ===== sv/plr_pkg.sv =====
// shared types, constants and helper functions of the pcm linear resampler
package plr_pkg;

    localparam int CH_LIMIT     = 2;
    localparam int FRAC_BITS    = 16;
    localparam int STEP_W       = 20;
    localparam int PHASE_W      = STEP_W + 1;
    localparam int GAIN_W       = 16;
    localparam int GAIN_FRAC    = 12;
    localparam int SAMPLE_W     = 32;
    localparam int ADDR_W       = 5;
    localparam int DATA_W       = 32;

    localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << FRAC_BITS;
    localparam logic [STEP_W-1:0]  MIN_STEP  = STEP_W'(1) << (FRAC_BITS - 4);

    // sample codings
    localparam logic [2:0] FMT_S8  = 3'd0;
    localparam logic [2:0] FMT_S16 = 3'd1;
    localparam logic [2:0] FMT_S32 = 3'd2;
    localparam logic [2:0] FMT_U8  = 3'd3;
    localparam logic [2:0] FMT_U16 = 3'd4;
    localparam logic [2:0] FMT_U32 = 3'd5;

    // register indexes
    localparam logic [2:0] REG_FORMAT   = 3'd0;
    localparam logic [2:0] REG_SRC_CH   = 3'd1;
    localparam logic [2:0] REG_OUT_CH   = 3'd2;
    localparam logic [2:0] REG_STEP     = 3'd3;
    localparam logic [2:0] REG_GAIN     = 3'd4;

    localparam logic [2:0]        FORMAT_RST = FMT_S16;
    localparam logic [1:0]        CHAN_RST   = 2'd2;
    localparam logic [STEP_W-1:0] STEP_RST   = STEP_W'(1) << FRAC_BITS;
    localparam logic [GAIN_W-1:0] GAIN_RST   = GAIN_W'(1) << GAIN_FRAC;

    typedef struct packed {
        logic [2:0]        sample_format;
        logic [1:0]        source_channels;
        logic [1:0]        output_channels;
        logic [STEP_W-1:0] step;
        logic [GAIN_W-1:0] gain;
    } cfg_t;

    typedef struct packed {
        logic [31:0] raw_first;
        logic [31:0] raw_second;
        logic        final_frame;
    } frame_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_first;
        logic signed [SAMPLE_W-1:0] out_second;
        logic                       run_end;
    } sample_t;

    typedef struct packed {
        logic load_frame;
        logic do_mul;
        logic do_gain;
        logic do_emit;
        logic commit;
        logic rearm;
        logic rep;
    } dp_cmd_t;

    typedef struct packed {
        logic held_valid;
        logic phase_lt_one;
        logic final_flag;
        logic out_free;
    } dp_status_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RUN  = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_GAIN = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    function automatic logic signed [SAMPLE_W-1:0] decode(
        input logic [2:0]  fmt,
        input logic [31:0] r
    );
        logic signed [SAMPLE_W-1:0] d;
        case (fmt)
            FMT_S8:  d = {r[7:0], 24'd0};
            FMT_S16: d = {r[15:0], 16'd0};
            FMT_S32: d = r;
            FMT_U8:  d = {~r[7], r[6:0], 24'd0};
            FMT_U16: d = {~r[15], r[14:0], 16'd0};
            FMT_U32: d = {~r[31], r[30:0]};
            default: d = '0;
        endcase
        return d;
    endfunction

    function automatic logic [1:0] clamp_ch(input logic [1:0] c);
        logic [1:0] r;
        r = c;
        if (r == 2'd0)
        begin
            r = 2'd1;
        end
        if (r == 2'd3)
        begin
            r = 2'd2;
        end
        if (int'(r) > CH_LIMIT)
        begin
            r = 2'(CH_LIMIT);
        end
        return r;
    endfunction

endpackage

// ===== sv/plr_regs.sv =====
// apb configuration register file
module plr_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [plr_pkg::ADDR_W-1:0]  paddr,
    input  logic [plr_pkg::DATA_W-1:0]  pwdata,
    output logic [plr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output plr_pkg::cfg_t               cfg
);

    plr_pkg::cfg_t cfg_reg;
    logic [2:0]    idx;
    logic          wr;

    assign pready = 1'b1;
    assign idx    = paddr[plr_pkg::ADDR_W-1:2];
    assign wr     = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_format   <= plr_pkg::FORMAT_RST;
            cfg_reg.source_channels <= plr_pkg::CHAN_RST;
            cfg_reg.output_channels <= plr_pkg::CHAN_RST;
            cfg_reg.step            <= plr_pkg::STEP_RST;
            cfg_reg.gain            <= plr_pkg::GAIN_RST;
        end
        else if (wr)
        begin
            case (idx)
                plr_pkg::REG_FORMAT: cfg_reg.sample_format   <= pwdata[2:0];
                plr_pkg::REG_SRC_CH: cfg_reg.source_channels <= pwdata[1:0];
                plr_pkg::REG_OUT_CH: cfg_reg.output_channels <= pwdata[1:0];
                plr_pkg::REG_STEP:   cfg_reg.step  <= pwdata[plr_pkg::STEP_W-1:0];
                plr_pkg::REG_GAIN:   cfg_reg.gain  <= pwdata[plr_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            plr_pkg::REG_FORMAT: prdata = plr_pkg::DATA_W'(cfg_reg.sample_format);
            plr_pkg::REG_SRC_CH: prdata = plr_pkg::DATA_W'(cfg_reg.source_channels);
            plr_pkg::REG_OUT_CH: prdata = plr_pkg::DATA_W'(cfg_reg.output_channels);
            plr_pkg::REG_STEP:   prdata = plr_pkg::DATA_W'(cfg_reg.step);
            plr_pkg::REG_GAIN:   prdata = plr_pkg::DATA_W'(cfg_reg.gain);
            default:             prdata = '0;
        endcase
    end

endmodule

// ===== sv/plr_ctrl.sv =====
// sequencing state machine of the resampler
module plr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                frame_valid,
    output logic                frame_ready,
    input  plr_pkg::dp_status_t sts,
    output plr_pkg::dp_cmd_t    cmd
);

    plr_pkg::state_t state_reg;
    plr_pkg::state_t state_next;
    logic            rep_reg;
    logic            rep_next;

    assign frame_ready = (state_reg == plr_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plr_pkg::ST_IDLE;
            rep_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rep_reg   <= rep_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        rep_next       = rep_reg;
        cmd            = '0;
        cmd.rep        = rep_reg;
        case (state_reg)
            plr_pkg::ST_IDLE:
            begin
                if (frame_valid)
                begin
                    cmd.load_frame = 1'b1;
                    state_next     = plr_pkg::ST_RUN;
                end
            end
            plr_pkg::ST_RUN:
            begin
                if (!rep_reg)
                begin
                    if (sts.held_valid && sts.phase_lt_one)
                    begin
                        state_next = plr_pkg::ST_MUL;
                    end
                    else
                    begin
                        // new frame becomes the held one
                        cmd.commit = 1'b1;
                        if (sts.final_flag)
                        begin
                            rep_next = 1'b1;
                        end
                        else
                        begin
                            state_next = plr_pkg::ST_IDLE;
                        end
                    end
                end
                else
                begin
                    if (sts.phase_lt_one)
                    begin
                        state_next = plr_pkg::ST_MUL;
                    end
                    else
                    begin
                        cmd.rearm  = 1'b1;
                        rep_next   = 1'b0;
                        state_next = plr_pkg::ST_IDLE;
                    end
                end
            end
            plr_pkg::ST_MUL:
            begin
                cmd.do_mul = 1'b1;
                state_next = plr_pkg::ST_GAIN;
            end
            plr_pkg::ST_GAIN:
            begin
                cmd.do_gain = 1'b1;
                state_next  = plr_pkg::ST_OUT;
            end
            plr_pkg::ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.do_emit = 1'b1;
                    state_next  = plr_pkg::ST_RUN;
                end
            end
            default:
            begin
                state_next = plr_pkg::ST_IDLE;
                rep_next   = 1'b0;
            end
        endcase
    end

endmodule

// ===== sv/plr_dp.sv =====
// datapath: decode, frame hold, phase, interpolation, gain, saturation, output register
module plr_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  plr_pkg::cfg_t       cfg,
    input  plr_pkg::frame_t     frame,
    input  plr_pkg::dp_cmd_t    cmd,
    output plr_pkg::dp_status_t sts,
    output plr_pkg::sample_t    sample,
    output logic                sample_valid,
    input  logic                sample_ready
);

    localparam int SW      = plr_pkg::SAMPLE_W;
    localparam int DIFF_W  = SW + 1;
    localparam int IPROD_W = DIFF_W + plr_pkg::FRAC_BITS + 1;
    localparam int GPROD_W = DIFF_W + plr_pkg::GAIN_W + 1;
    localparam logic signed [GPROD_W-1:0] SAT_HI = (GPROD_W'(1) <<< (SW - 1)) - 1;
    localparam logic signed [GPROD_W-1:0] SAT_LO = -(GPROD_W'(1) <<< (SW - 1));

    logic signed [SW-1:0]       held_reg  [2];
    logic signed [SW-1:0]       cur_reg   [2];
    logic signed [SW-1:0]       a_reg     [2];
    logic signed [IPROD_W-1:0]  prod_reg  [2];
    logic signed [GPROD_W-1:0]  gprod_reg [2];
    logic                       final_reg;
    logic                       last_reg;
    logic                       held_valid_reg;
    logic [plr_pkg::PHASE_W-1:0] phase_reg;
    plr_pkg::sample_t           sample_reg;
    logic                       sample_valid_reg;

    logic [plr_pkg::STEP_W-1:0]    st;
    logic [plr_pkg::PHASE_W-1:0]   phase_sum;
    logic [plr_pkg::FRAC_BITS-1:0] frac;
    logic                          last_next;
    logic signed [SW-1:0]          a_next    [2];
    logic signed [DIFF_W-1:0]      diff      [2];
    logic signed [IPROD_W-1:0]     prod_next [2];
    logic signed [IPROD_W-1:0]     prod_sh   [2];
    logic signed [DIFF_W-1:0]      interp    [2];
    logic signed [GPROD_W-1:0]     gprod_next[2];
    logic signed [GPROD_W-1:0]     scaled    [2];
    logic signed [SW-1:0]          sat       [2];
    logic [1:0]                    sc;
    logic [1:0]                    oc;
    plr_pkg::sample_t              sample_next;

    assign st = (cfg.step < plr_pkg::MIN_STEP) ? plr_pkg::MIN_STEP : cfg.step;
    assign phase_sum = phase_reg + plr_pkg::PHASE_W'(st);
    assign frac = cmd.rep ? '0 : phase_reg[plr_pkg::FRAC_BITS-1:0];

    // last result of the frame: phase crosses one and no repeat run follows
    assign last_next = (phase_sum >= plr_pkg::PHASE_ONE)
        && (cmd.rep || !final_reg || (phase_sum >= (plr_pkg::PHASE_ONE << 1)));

    assign sc = plr_pkg::clamp_ch(cfg.source_channels);
    assign oc = plr_pkg::clamp_ch(cfg.output_channels);

    always_comb
    begin
        for (int ch = 0; ch < 2; ch++)
        begin
            a_next[ch]     = cmd.rep ? cur_reg[ch] : held_reg[ch];
            diff[ch]       = $signed({cur_reg[ch][SW-1], cur_reg[ch]})
                           - $signed({a_next[ch][SW-1], a_next[ch]});
            prod_next[ch]  = diff[ch] * $signed({1'b0, frac});
            prod_sh[ch]    = prod_reg[ch] >>> plr_pkg::FRAC_BITS;
            interp[ch]     = $signed({a_reg[ch][SW-1], a_reg[ch]})
                           + $signed(prod_sh[ch][DIFF_W-1:0]);
            gprod_next[ch] = interp[ch] * $signed({1'b0, cfg.gain});
            scaled[ch]     = gprod_reg[ch] >>> plr_pkg::GAIN_FRAC;
            if (scaled[ch] > SAT_HI)
            begin
                sat[ch] = SAT_HI[SW-1:0];
            end
            else if (scaled[ch] < SAT_LO)
            begin
                sat[ch] = SAT_LO[SW-1:0];
            end
            else
            begin
                sat[ch] = scaled[ch][SW-1:0];
            end
        end
    end

    // channel mapping: mono output takes the last source channel
    always_comb
    begin
        sample_next.out_first  = ((oc == 2'd1) && (sc == 2'd2)) ? sat[1] : sat[0];
        sample_next.out_second = (oc == 2'd2) ? ((sc == 2'd2) ? sat[1] : sat[0]) : '0;
        sample_next.run_end    = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg   <= 1'b0;
            phase_reg        <= '0;
            sample_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.do_mul)
            begin
                phase_reg <= phase_sum;
            end
            else if (cmd.commit && held_valid_reg)
            begin
                phase_reg <= phase_reg - plr_pkg::PHASE_ONE;
            end
            else if (cmd.rearm)
            begin
                phase_reg <= '0;
            end

            if (cmd.commit)
            begin
                held_valid_reg <= 1'b1;
            end
            else if (cmd.rearm)
            begin
                held_valid_reg <= 1'b0;
            end

            if (cmd.do_emit)
            begin
                sample_valid_reg <= 1'b1;
            end
            else if (sample_ready)
            begin
                sample_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_frame)
        begin
            cur_reg[0] <= plr_pkg::decode(cfg.sample_format, frame.raw_first);
            cur_reg[1] <= plr_pkg::decode(cfg.sample_format, frame.raw_second);
            final_reg  <= frame.final_frame;
        end
        if (cmd.commit)
        begin
            held_reg[0] <= cur_reg[0];
            held_reg[1] <= cur_reg[1];
        end
        if (cmd.do_mul)
        begin
            last_reg <= last_next;
            for (int ch = 0; ch < 2; ch++)
            begin
                a_reg[ch]    <= a_next[ch];
                prod_reg[ch] <= prod_next[ch];
            end
        end
        if (cmd.do_gain)
        begin
            for (int ch = 0; ch < 2; ch++)
            begin
                gprod_reg[ch] <= gprod_next[ch];
            end
        end
        if (cmd.do_emit)
        begin
            sample_reg <= sample_next;
        end
    end

    assign sts.held_valid   = held_valid_reg;
    assign sts.phase_lt_one = (phase_reg < plr_pkg::PHASE_ONE);
    assign sts.final_flag   = final_reg;
    assign sts.out_free     = !sample_valid_reg || sample_ready;

    assign sample       = sample_reg;
    assign sample_valid = sample_valid_reg;

endmodule

// ===== sv/pcm_linear_resampler_with_gain.sv =====
// top level of the pcm linear resampler with gain
// each result passes the phase check, interpolation multiply, gain multiply and output load
// states in turn; the output load waits while the output register holds an unaccepted result
// the input is held (frame_ready low) from a frame's transfer until all its interpolated results,
// and for a final frame its repeated results too, have been loaded into the output register
// rst_n clears the registers to their reset values, drops the held frame and zeroes the phase
module pcm_linear_resampler_with_gain (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [plr_pkg::ADDR_W-1:0]  paddr,
    input  logic [plr_pkg::DATA_W-1:0]  pwdata,
    output logic [plr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        frame_valid,
    output logic                        frame_ready,
    input  plr_pkg::frame_t             frame,
    output logic                        sample_valid,
    input  logic                        sample_ready,
    output plr_pkg::sample_t            sample
);

    plr_pkg::cfg_t       cfg;
    plr_pkg::dp_cmd_t    cmd;
    plr_pkg::dp_status_t sts;

    plr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    plr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    plr_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .frame        (frame),
        .cmd          (cmd),
        .sts          (sts),
        .sample       (sample),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready)
    );

endmodule

// ===== sv/plr_checker.sv =====
// port-level assertions of the resampler and their bind
module plr_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             frame_valid,
    input logic             frame_ready,
    input plr_pkg::frame_t  frame,
    input logic             sample_valid,
    input logic             sample_ready,
    input plr_pkg::sample_t sample,
    input logic             pready
);

    // a stalled result holds
    a_sample_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_ready |=> sample_valid && $stable(sample))
        else $error("result changed while stalled");

    // a waiting source frame holds
    a_frame_hold: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_ready |=> frame_valid && $stable(frame))
        else $error("source frame changed while waiting");

    // every frame transfer is followed by at least one busy cycle
    a_busy_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_ready |=> !frame_ready)
        else $error("ready right after frame transfer");

    // a result that is not the last of its frame means more work is pending
    a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample.run_end |-> !frame_ready)
        else $error("frame ready while results of the previous frame remain");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid |-> pready)
        else $error("pready low");

endmodule

bind pcm_linear_resampler_with_gain plr_checker u_plr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_valid  (frame_valid),
    .frame_ready  (frame_ready),
    .frame        (frame),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .pready       (pready)
);

// ===== test/pcm_linear_resampler_with_gain_test.sv =====
// self-checking testbench for the pcm linear resampler with gain
module pcm_linear_resampler_with_gain_test;

    localparam logic [2:0] FMT_UNDEF    = 3'd6;
    localparam int         SETTLE_WAIT  = 20;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         TAIL_CYCLES  = 40;
    localparam longint     Q31_MAX      = 64'sh0000_0000_7FFF_FFFF;
    localparam longint     Q31_MIN      = -64'sh0000_0000_8000_0000;

    typedef logic signed [plr_pkg::SAMPLE_W-1:0] pair_t [2];

    typedef enum logic [1:0] {ACT_CONFIG, ACT_FRAME, ACT_KNOWN} act_t;

    typedef struct packed {
        act_t             kind;
        plr_pkg::cfg_t    settings;
        plr_pkg::frame_t  item;
        plr_pkg::sample_t want;
    } plan_row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [plr_pkg::ADDR_W-1:0]   paddr;
    logic [plr_pkg::DATA_W-1:0]   pwdata;
    logic [plr_pkg::DATA_W-1:0]   prdata;
    logic                         pready;
    logic                         frame_valid;
    logic                         frame_ready;
    plr_pkg::frame_t              frame;
    logic                         sample_valid;
    logic                         sample_ready;
    plr_pkg::sample_t             sample;

    // resampler mirror: settings, held frame, source phase
    plr_pkg::cfg_t    cur_cfg;
    pair_t            held_q31;
    logic             held_ok;
    longint           src_phase;
    plr_pkg::sample_t due_samples [32];

    plr_pkg::sample_t pending[$];
    int      errors;
    int      frames_sent;
    int      samples_seen;
    int      settings_done;
    logic    idle_on;
    logic    hold_req;

    pcm_linear_resampler_with_gain uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .frame_valid  (frame_valid),
        .frame_ready  (frame_ready),
        .frame        (frame),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic signed [plr_pkg::SAMPLE_W-1:0] to_q31(
        input logic [2:0]  fmt,
        input logic [31:0] raw
    );
        logic [31:0] w;
        case (fmt)
            plr_pkg::FMT_S8:  w = raw << 24;
            plr_pkg::FMT_S16: w = raw << 16;
            plr_pkg::FMT_S32: w = raw;
            plr_pkg::FMT_U8:  w = (raw ^ 32'h0000_0080) << 24;
            plr_pkg::FMT_U16: w = (raw ^ 32'h0000_8000) << 16;
            plr_pkg::FMT_U32: w = raw ^ 32'h8000_0000;
            default:          w = '0;
        endcase
        return w;
    endfunction

    function automatic int chan_count(input logic [1:0] c);
        int n;
        n = int'(c);
        if (n == 0)
        begin
            n = 1;
        end
        if (n == 3)
        begin
            n = 2;
        end
        if (n > plr_pkg::CH_LIMIT)
        begin
            n = plr_pkg::CH_LIMIT;
        end
        return n;
    endfunction

    // one output frame: interpolate each mapped channel, apply gain, saturate
    function automatic plr_pkg::sample_t mix_point(input pair_t a, input pair_t b,
                                                   input longint frac);
        int                                  sc;
        int                                  oc;
        int                                  total;
        int                                  si;
        longint                              v;
        longint                              g;
        logic signed [plr_pkg::SAMPLE_W-1:0] val [2];
        plr_pkg::sample_t                    s;
        sc = chan_count(cur_cfg.source_channels);
        oc = chan_count(cur_cfg.output_channels);
        total = (sc > oc) ? sc : oc;
        val[0] = '0;
        val[1] = '0;
        for (int c = 0; c < total; c++)
        begin
            si = c % sc;
            v = longint'(a[si])
                + (((longint'(b[si]) - longint'(a[si])) * frac) >>> plr_pkg::FRAC_BITS);
            g = (v * longint'(cur_cfg.gain)) >>> plr_pkg::GAIN_FRAC;
            if (g > Q31_MAX)
            begin
                g = Q31_MAX;
            end
            if (g < Q31_MIN)
            begin
                g = Q31_MIN;
            end
            val[c % oc] = g[31:0];
        end
        s.out_first  = val[0];
        s.out_second = (oc == 2) ? val[1] : '0;
        s.run_end    = 1'b0;
        return s;
    endfunction

    // fills due_samples with the outputs one source frame causes, returns their count
    function automatic int predict_frame(input plr_pkg::frame_t f);
        pair_t  cur;
        longint st;
        int     n;
        int     m;
        st = (cur_cfg.step < plr_pkg::MIN_STEP) ? longint'(plr_pkg::MIN_STEP)
                                                 : longint'(cur_cfg.step);
        cur[0] = to_q31(cur_cfg.sample_format, f.raw_first);
        cur[1] = to_q31(cur_cfg.sample_format, f.raw_second);
        n = 0;
        if (held_ok)
        begin
            while (src_phase < longint'(plr_pkg::PHASE_ONE) && n < 16)
            begin
                due_samples[n] = mix_point(held_q31, cur, src_phase);
                n++;
                src_phase += st;
            end
            src_phase -= longint'(plr_pkg::PHASE_ONE);
        end
        held_q31 = cur;
        held_ok = 1'b1;
        if (f.final_frame)
        begin
            // tail of the buffer repeats the last frame
            m = 0;
            while (src_phase < longint'(plr_pkg::PHASE_ONE) && m < 16)
            begin
                due_samples[n] = mix_point(cur, cur, 0);
                n++;
                m++;
                src_phase += st;
            end
            held_ok = 1'b0;
            src_phase = 0;
        end
        if (n > 0)
        begin
            due_samples[n-1].run_end = 1'b1;
        end
        return n;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_on)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_raw();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            4: return ($urandom & 32'hFFFF_FF00) | 32'h0000_0080;
            5: return ($urandom & 32'hFFFF_0000) | 32'h0000_7FFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic plr_pkg::cfg_t random_settings();
        plr_pkg::cfg_t c;
        c.sample_format   = 3'($urandom_range(0, 7));
        c.source_channels = 2'($urandom_range(0, 3));
        c.output_channels = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 5))
            0: c.step = '0;
            1: c.step = plr_pkg::STEP_W'($urandom_range(0, 4095));
            2: c.step = '1;
            3: c.step = plr_pkg::STEP_W'($urandom_range(4096, 65536));
            default: c.step = plr_pkg::STEP_W'($urandom_range(32768, 300000));
        endcase
        case ($urandom_range(0, 3))
            0: c.gain = '1;
            1: c.gain = plr_pkg::GAIN_RST;
            2: c.gain = '0;
            default: c.gain = plr_pkg::GAIN_W'($urandom);
        endcase
        return c;
    endfunction

    function automatic plan_row_t cfg_row(input logic [2:0] fmt, input logic [1:0] sc,
                                          input logic [1:0] oc,
                                          input logic [plr_pkg::STEP_W-1:0] st,
                                          input logic [plr_pkg::GAIN_W-1:0] g);
        plan_row_t r;
        r = '0;
        r.kind = ACT_CONFIG;
        r.settings.sample_format   = fmt;
        r.settings.source_channels = sc;
        r.settings.output_channels = oc;
        r.settings.step            = st;
        r.settings.gain            = g;
        return r;
    endfunction

    function automatic plan_row_t frame_row(input logic [31:0] r1, input logic [31:0] r2,
                                            input logic fin);
        plan_row_t r;
        r = '0;
        r.kind = ACT_FRAME;
        r.item.raw_first   = r1;
        r.item.raw_second  = r2;
        r.item.final_frame = fin;
        return r;
    endfunction

    // frame whose single output is known by inspection
    function automatic plan_row_t known_row(input logic [31:0] r1, input logic [31:0] r2,
                                            input logic [31:0] o1, input logic [31:0] o2);
        plan_row_t r;
        r = frame_row(r1, r2, 1'b0);
        r.kind = ACT_KNOWN;
        r.want.out_first  = o1;
        r.want.out_second = o2;
        r.want.run_end    = 1'b1;
        return r;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] mask;
        case (idx)
            plr_pkg::REG_FORMAT: mask = 32'h0000_0007;
            plr_pkg::REG_SRC_CH: mask = 32'h0000_0003;
            plr_pkg::REG_OUT_CH: mask = 32'h0000_0003;
            plr_pkg::REG_STEP:   mask = 32'h000F_FFFF;
            default:             mask = 32'h0000_FFFF;
        endcase
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= plr_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        // read back through the same port
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if ((prdata & mask) !== (value & mask))
        begin
            $error("register %0d: expected %0h, got %0h", idx, value & mask, prdata & mask);
            errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // drain, let the block settle, then program all registers
    task automatic apply_settings(input plr_pkg::cfg_t c);
        frame_valid <= 1'b0;
        while (pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_WAIT) @(posedge clk);
        write_reg(plr_pkg::REG_FORMAT, 32'(c.sample_format));
        write_reg(plr_pkg::REG_SRC_CH, 32'(c.source_channels));
        write_reg(plr_pkg::REG_OUT_CH, 32'(c.output_channels));
        write_reg(plr_pkg::REG_STEP, 32'(c.step));
        write_reg(plr_pkg::REG_GAIN, 32'(c.gain));
        cur_cfg = c;
        settings_done++;
    endtask

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_frame(input plr_pkg::frame_t f, input logic known,
                              input plr_pkg::sample_t want);
        int gap;
        int n;
        gap = pick_gap();
        if (gap > 0)
        begin
            frame_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        frame       <= f;
        frame_valid <= 1'b1;
        do @(posedge clk); while (!frame_ready);
        n = predict_frame(f);
        if (known)
        begin
            pending.push_back(want);
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                pending.push_back(due_samples[i]);
            end
        end
        frames_sent++;
        @(negedge clk);
    endtask

    // output side: check each transfer, then pick ready for the next cycle
    initial
    begin
        int               stall_left;
        int               hold_left;
        plr_pkg::sample_t want;
        stall_left = 0;
        hold_left = 0;
        sample_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (sample_valid && sample_ready)
            begin
                samples_seen++;
                if (pending.size() == 0)
                begin
                    $error("sample with nothing pending: %0d %0d %b",
                           sample.out_first, sample.out_second, sample.run_end);
                    errors++;
                end
                else
                begin
                    want = pending.pop_front();
                    if (sample.out_first !== want.out_first)
                    begin
                        $error("out_first: expected %0d, got %0d",
                               want.out_first, sample.out_first);
                        errors++;
                    end
                    if (sample.out_second !== want.out_second)
                    begin
                        $error("out_second: expected %0d, got %0d",
                               want.out_second, sample.out_second);
                        errors++;
                    end
                    if (sample.run_end !== want.run_end)
                    begin
                        $error("run_end: expected %b, got %b", want.run_end, sample.run_end);
                        errors++;
                    end
                end
            end
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                sample_ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                sample_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                sample_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        plan_row_t       plan[$];
        int              sent;
        int              len;
        logic            noise;
        logic            fin;
        plr_pkg::frame_t f;

        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        frame_valid = 1'b0;
        frame       = '0;
        errors        = 0;
        frames_sent   = 0;
        samples_seen  = 0;
        settings_done = 0;
        idle_on  = 1'b1;
        hold_req = 1'b0;
        cur_cfg.sample_format   = plr_pkg::FORMAT_RST;
        cur_cfg.source_channels = plr_pkg::CHAN_RST;
        cur_cfg.output_channels = plr_pkg::CHAN_RST;
        cur_cfg.step            = plr_pkg::STEP_RST;
        cur_cfg.gain            = plr_pkg::GAIN_RST;
        held_q31[0] = '0;
        held_q31[1] = '0;
        held_ok   = 1'b0;
        src_phase = 0;

        // reset settings: s16 stereo, unit step, unity gain
        plan.push_back(frame_row(32'h0000_7FFF, 32'h0000_8000, 1'b0));
        plan.push_back(known_row(32'hFFFF_0000, 32'h0000_FFFF, 32'h7FFF_0000, 32'h8000_0000));
        plan.push_back(frame_row(32'h0000_0001, 32'hFFFF_FFFF, 1'b1));
        // smallest step, largest gain: 16 outputs per frame, saturation
        plan.push_back(cfg_row(plr_pkg::FMT_S32, 2'd2, 2'd2, 20'd4096, 16'hFFFF));
        plan.push_back(frame_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
        plan.push_back(frame_row(32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
        plan.push_back(frame_row(32'h0000_0000, 32'hFFFF_FFFF, 1'b1));
        // step under the floor, zero gain, mono source to stereo, final on first frame
        plan.push_back(cfg_row(plr_pkg::FMT_U8, 2'd1, 2'd2, 20'd0, 16'd0));
        plan.push_back(frame_row(32'hFFFF_FF00, 32'h1234_5678, 1'b1));
        // largest step, stereo source to mono output, frames with no output
        plan.push_back(cfg_row(plr_pkg::FMT_U16, 2'd2, 2'd1, 20'hFFFFF, plr_pkg::GAIN_RST));
        plan.push_back(frame_row(32'h0000_0000, 32'h0000_FFFF, 1'b0));
        plan.push_back(known_row(32'h0000_8000, 32'hFFFF_0000, 32'h7FFF_0000, 32'h0000_0000));
        plan.push_back(frame_row(32'h0000_1234, 32'h0000_ABCD, 1'b0));
        plan.push_back(frame_row(32'h0000_0000, 32'h0000_0000, 1'b1));
        // out-of-range channel counts, fractional step
        plan.push_back(cfg_row(plr_pkg::FMT_S8, 2'd3, 2'd0, 20'd98304, 16'd8192));
        plan.push_back(frame_row(32'h0000_0080, 32'h0000_007F, 1'b0));
        plan.push_back(frame_row(32'h0000_007F, 32'h0000_0080, 1'b0));
        plan.push_back(frame_row(32'hFFFF_FFFF, 32'h0000_0001, 1'b0));
        plan.push_back(frame_row(32'h0000_0001, 32'hFFFF_FFFF, 1'b1));
        // undefined coding decodes to silence
        plan.push_back(cfg_row(FMT_UNDEF, 2'd1, 2'd1, 20'd32768, plr_pkg::GAIN_RST));
        plan.push_back(frame_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        plan.push_back(frame_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
        plan.push_back(cfg_row(plr_pkg::FMT_U32, 2'd0, 2'd3, 20'd20000, 16'd4095));
        plan.push_back(frame_row(32'h8000_0000, 32'h0000_0000, 1'b0));
        plan.push_back(frame_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        plan.push_back(frame_row(32'h0000_0000, 32'h0000_0000, 1'b1));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            case (plan[i].kind)
                ACT_CONFIG: apply_settings(plan[i].settings);
                ACT_FRAME:  send_frame(plan[i].item, 1'b0, plan[i].want);
                default:    send_frame(plan[i].item, 1'b1, plan[i].want);
            endcase
        end

        // random buffers under random settings
        for (int ph = 0; ph < 9; ph++)
        begin
            apply_settings(random_settings());
            idle_on = (ph % 3 != 1);
            if (ph == 4)
            begin
                hold_req = 1'b1;
            end
            sent = 0;
            while (sent < 15)
            begin
                len = $urandom_range(1, 8);
                noise = ($urandom_range(0, 5) == 0);
                for (int k = 0; k < len; k++)
                begin
                    fin = noise ? 1'($urandom_range(0, 1)) : (k == len - 1);
                    f.raw_first   = pick_raw();
                    f.raw_second  = pick_raw();
                    f.final_frame = fin;
                    send_frame(f, 1'b0, '0);
                    sent++;
                end
            end
        end

        frame_valid <= 1'b0;
        while (pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("%0d source frames sent, %0d output frames checked", frames_sent, samples_seen);
        $display("%0d register settings, one long output hold-off", settings_done);
        if (errors == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial
    begin
        #12000000;
        $display("timed out with %0d output frames outstanding", pending.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
